/* sv/integer_to_custom_radix_digits_assert.svh */
// Assertion macros for the radix conversion block.
`ifndef INTEGER_TO_CUSTOM_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_CUSTOM_RADIX_DIGITS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ITCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itcr: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ITCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itcr: next-cycle check failed");

`endif

/* sv/itcr_pkg.sv */
// Shared constants, types and helpers for the radix conversion block.
package itcr_pkg;

   localparam int VALUE_W         = 32;
   localparam int DIGIT_W         = 4;
   localparam int SYM_W           = 8;
   localparam int COUNT_W         = 5;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_IDX_W       = 2;
   localparam int SYMS_PER_WORD   = CSR_DATA_W / SYM_W;
   localparam int MAX_SYMBOLS_DEF = 16;
   localparam int STACK_DEPTH     = VALUE_W;
   localparam int DEPTH_W         = $clog2(STACK_DEPTH + 1);

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd10;
   localparam logic [COUNT_W-1:0] MIN_SYMBOLS = 5'd2;

   localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] CHAR_LOW   = 8'd32;
   localparam logic [SYM_W-1:0] CHAR_HIGH  = 8'd127;
   localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUNT  = 2'd0,
      CSR_SYM_LO = 2'd1,
      CSR_SYM_HI = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SIGN,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic run;
   } div_ctl_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic               quot_zero;
      logic [DIGIT_W-1:0] rem;
   } div_stat_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctl_type;

   function automatic logic [SYM_W-1:0] sym_reset(input int k);
      return (k < int'(COUNT_RESET)) ? SYM_W'(int'(CHAR_ZERO) + k) : '0;
   endfunction

endpackage

/* sv/integer_to_custom_radix_digits.sv */
// Top level: signed integer to text in a configurable radix, one character per beat.
//
// req_* carries one 32-bit two's complement value per beat. rsp_* returns its
// text one character per beat, most significant digit first, with a leading '-'
// for negative values and rsp_tlast on the final character. csr_* writes the
// symbol count (index 0) and the alphabet bytes (indexes 1 and 2); write only
// while the block is idle. An alphabet that fails the check produces no beats.
// Each digit comes from a bit-serial divider that restarts and then works out 32
// quotient bits; a value occupies the block until its last digit is emitted.
// Digits leave at one beat per cycle while rsp_tready is high. An invalid
// alphabet sends the block from the check state straight back to idle.
// The output register holds a beat while rsp_tready is low, and the sequencer
// holds with it in the sign and emit states; the next value is taken while the
// final beat still waits. Reset is synchronous: it empties the pipeline and
// restores count 10 with the decimal alphabet.
module integer_to_custom_radix_digits
   import itcr_pkg::*;
#(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // [31:0] value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SYM_W-1:0]      rsp_tdata,   // [7:0] symbol
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

   logic [COUNT_W-1:0]                count_ff;
   logic [MAX_SYMBOLS-1:0][SYM_W-1:0] sym_ff;
   logic [COUNT_W-1:0]                radix;
   logic                              alpha_ok;

   state_type state_ff;
   state_type state_in;
   logic      neg_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [SYM_W-1:0]   rsp_data_ff;
   logic               rsp_last_ff;

   div_ctl_type        div_ctl;
   div_stat_type       div_stat;
   stk_ctl_type        stk_ctl;
   logic [DIGIT_W-1:0] stk_top;
   logic [DEPTH_W-1:0] stk_depth;
   logic [VALUE_W-1:0] dividend;

   logic               out_free;
   logic               emit_load;
   logic [SYM_W-1:0]   emit_sym;
   logic               emit_last;
   logic               div_finish;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         for (int k = 0; k < MAX_SYMBOLS; k++) begin
            sym_ff[k] <= sym_reset(k);
         end
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_COUNT: begin
               count_ff <= csr_data[COUNT_W-1:0];
            end
            CSR_SYM_LO: begin
               for (int k = 0; k < MAX_SYMBOLS; k++) begin
                  if (k < SYMS_PER_WORD) begin
                     sym_ff[k] <= csr_data[(k % SYMS_PER_WORD) * SYM_W +: SYM_W];
                  end
               end
            end
            CSR_SYM_HI: begin
               for (int k = 0; k < MAX_SYMBOLS; k++) begin
                  if (k >= SYMS_PER_WORD) begin
                     sym_ff[k] <= csr_data[(k % SYMS_PER_WORD) * SYM_W +: SYM_W];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign radix = (count_ff > COUNT_W'(MAX_SYMBOLS)) ? COUNT_W'(MAX_SYMBOLS) : count_ff;

   itcr_alpha_check #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_check (
      .clock   (clock),
      .reset   (reset),
      .symbols (sym_ff),
      .radix   (radix),
      .ok      (alpha_ok)
   );

   assign dividend = req_tdata[VALUE_W-1] ? (~req_tdata + VALUE_W'(1)) : req_tdata;

   itcr_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (dividend),
      .radix    (radix),
      .stat     (div_stat)
   );

   itcr_digit_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .din   (div_stat.rem),
      .top   (stk_top),
      .depth (stk_depth)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign div_finish = div_stat.quot_zero || (stk_depth == DEPTH_W'(STACK_DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!alpha_ok) begin
               state_in = ST_IDLE;
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done && div_finish) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && stk_depth == DEPTH_W'(1)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      div_ctl.load = (state_ff == ST_IDLE) && req_tvalid;
      div_ctl.run  = ((state_ff == ST_CHECK) && alpha_ok && !neg_ff) ||
                     ((state_ff == ST_SIGN) && out_free) ||
                     ((state_ff == ST_DIV) && div_stat.done && !div_finish);
      stk_ctl.push = (state_ff == ST_DIV) && div_stat.done;
      stk_ctl.pop  = (state_ff == ST_EMIT) && out_free;
      emit_load    = ((state_ff == ST_SIGN) || (state_ff == ST_EMIT)) && out_free;
      emit_sym     = (state_ff == ST_SIGN) ? CHAR_MINUS : sym_ff[stk_top[IDX_W-1:0]];
      emit_last    = (state_ff == ST_EMIT) && (stk_depth == DEPTH_W'(1));
   end

   always_comb begin
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ctl.load) neg_ff <= req_tdata[VALUE_W-1];
      if (emit_load) begin
         rsp_data_ff <= emit_sym;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`include "integer_to_custom_radix_digits_assert.svh"

   `ITCR_ASSERT_NOW(a_emit_has_digit, clock, reset, state_ff == ST_EMIT, stk_depth != '0)
   `ITCR_ASSERT_NOW(a_div_only_in_div, clock, reset, div_stat.busy, state_ff == ST_DIV)
   `ITCR_ASSERT_NEXT(a_accept_to_check, clock, reset, req_tvalid && req_tready, state_ff == ST_CHECK)

endmodule

/* sv/itcr_alpha_check.sv */
// Alphabet validity check over the active symbols, registered.
module itcr_alpha_check
   import itcr_pkg::*;
#(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [MAX_SYMBOLS-1:0][SYM_W-1:0] symbols,
   input  logic [COUNT_W-1:0]                radix,
   output logic                              ok
);

   logic ok_ff;
   logic ok_in;
   logic bad;

   always_comb begin
      bad = 1'b0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (COUNT_W'(i) < radix) begin
            if (symbols[i] < CHAR_LOW || symbols[i] >= CHAR_HIGH ||
                symbols[i] == CHAR_PLUS || symbols[i] == CHAR_MINUS) begin
               bad = 1'b1;
            end
         end
         for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
            if (COUNT_W'(j) < radix && symbols[i] == symbols[j]) begin
               bad = 1'b1;
            end
         end
      end
      ok_in = (radix >= MIN_SYMBOLS) && !bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff <= 1'b0;
      end else begin
         ok_ff <= ok_in;
      end
   end

   assign ok = ok_ff;

endmodule

/* sv/itcr_serial_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, small radix.
module itcr_serial_div
   import itcr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_ctl_type        ctl,
   input  logic [VALUE_W-1:0] dividend,
   input  logic [COUNT_W-1:0] radix,
   output div_stat_type       stat
);

   localparam int CNT_W = $clog2(VALUE_W);

   logic [VALUE_W-1:0] mag_ff;
   logic [DIGIT_W-1:0] rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   logic [DIGIT_W:0]   trial;
   logic [DIGIT_W:0]   diff;
   logic               ge;
   logic [DIGIT_W-1:0] rem_step;

   always_comb begin
      trial    = {rem_ff, mag_ff[VALUE_W-1]};
      ge       = trial >= (DIGIT_W + 1)'(radix);
      diff     = trial - (DIGIT_W + 1)'(radix);
      rem_step = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.run) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mag_ff <= dividend;
      end else if (ctl.run) begin
         rem_ff <= '0;
      end else if (busy_ff) begin
         mag_ff <= {mag_ff[VALUE_W-2:0], ge};
         rem_ff <= rem_step;
      end
   end

   assign stat.busy      = busy_ff;
   assign stat.done      = done_ff;
   assign stat.quot_zero = (mag_ff == '0);
   assign stat.rem       = rem_ff;

endmodule

/* sv/itcr_digit_stack.sv */
// Digit stack as a shift register: push and pop at the head.
module itcr_digit_stack
   import itcr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  stk_ctl_type        ctl,
   input  logic [DIGIT_W-1:0] din,
   output logic [DIGIT_W-1:0] top,
   output logic [DEPTH_W-1:0] depth
);

   logic [DIGIT_W-1:0] stk_ff [STACK_DEPTH];
   logic [DEPTH_W-1:0] depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else if (ctl.push) begin
         depth_ff <= depth_ff + DEPTH_W'(1);
      end else if (ctl.pop) begin
         depth_ff <= depth_ff - DEPTH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         stk_ff[0] <= din;
         for (int k = 1; k < STACK_DEPTH; k++) begin
            stk_ff[k] <= stk_ff[k-1];
         end
      end else if (ctl.pop) begin
         for (int k = 0; k < STACK_DEPTH - 1; k++) begin
            stk_ff[k] <= stk_ff[k+1];
         end
      end
   end

   assign top   = stk_ff[0];
   assign depth = depth_ff;

endmodule
